>>> rtl/assert_macros.svh
// assertion helpers, sampled on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge out of reset
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication form: antecedent at this edge, consequent at the same edge
`define SPQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication form: consequent in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DefaultDepth = 16;

  localparam int unsigned PriW   = 8;
  localparam int unsigned AgeW   = 8;
  localparam int unsigned NameAW = 64;
  localparam int unsigned NameBW = 64;
  localparam int unsigned NameCW = 32;
  localparam int unsigned OccW   = 5;

  localparam int unsigned RecW      = PriW + AgeW + NameAW + NameBW + NameCW;
  localparam int unsigned InDataW   = ((RecW + 7) / 8) * 8;
  localparam int unsigned OutDataW  = ((RecW + OccW + 7) / 8) * 8;
  localparam int unsigned StatusW   = 2;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // one stored record, priority in the low bits
  typedef struct packed {
    logic [NameCW-1:0] name_c;
    logic [NameBW-1:0] name_b;
    logic [NameAW-1:0] name_a;
    logic [AgeW-1:0]   age;
    logic [PriW-1:0]   pri;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic insert;
    logic remove;
    logic load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

>>> rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake control, request decode and status code of the priority queue.
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  action_e  action_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output status_e  status_o,
  input  dp_stat_t dp_stat_i,
  output cmd_t     cmd_o
);

  typedef enum logic {
    OUT_IDLE,
    OUT_HOLD
  } state_e;

  state_e  state_q;
  status_e status_q;
  status_e status_d;
  logic    accept;

  // the result register frees up in the same cycle it is taken
  assign in_ready_o  = (state_q == OUT_IDLE) || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == OUT_HOLD);
  assign status_o    = status_q;

  always_comb begin
    cmd_o       = '0;
    cmd_o.load  = accept;
    status_d    = ST_OK;
    priority if (action_i == ACT_REMOVE) begin
      if (dp_stat_i.empty) begin
        status_d = ST_EMPTY;
      end else begin
        cmd_o.remove = accept;
      end
    end else begin
      if (dp_stat_i.full) begin
        status_d = ST_FULL;
      end else begin
        cmd_o.insert = accept;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= OUT_IDLE;
      status_q <= ST_OK;
    end else begin
      unique case (state_q)
        OUT_IDLE: begin
          if (accept) begin
            state_q  <= OUT_HOLD;
            status_q <= status_d;
          end
        end
        OUT_HOLD: begin
          if (accept) begin
            status_q <= status_d;
          end else if (out_ready_i) begin
            state_q <= OUT_IDLE;
          end
        end
        default: state_q <= OUT_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/spq_dpath.sv
// ----------------------------------------------------------------------------
// spq_dpath
// Sorted row of record cells with shift insert and remove, count and result.
// ----------------------------------------------------------------------------
module spq_dpath import spq_pkg::*; #(
  parameter int unsigned Depth = DefaultDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  input  entry_t          in_rec_i,
  output dp_stat_t        dp_stat_o,
  output entry_t          res_rec_o,
  output logic [OccW-1:0] occupancy_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            cell_q [Depth];
  entry_t            cell_d [Depth];
  logic [Depth-1:0]  after_new;
  logic [CntW-1:0]   count_q;
  logic [CntW-1:0]   count_d;
  logic [CntW+OccW-1:0] occ_ext;
  entry_t            res_q;
  logic [OccW-1:0]   occ_q;

  assign dp_stat_o.full  = (count_q == CntW'(Depth));
  assign dp_stat_o.empty = (count_q == '0);

  // each cell decides locally; held cells are sorted, so after_new is a thermometer
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    assign after_new[i] = (count_q <= CntW'(i)) || (cell_q[i].pri > in_rec_i.pri);

    always_comb begin
      cell_d[i] = cell_q[i];
      if (cmd_i.insert && after_new[i]) begin
        if (i == 0) begin
          cell_d[i] = in_rec_i;
        end else if (!after_new[(i == 0) ? 0 : i - 1]) begin
          cell_d[i] = in_rec_i;
        end else begin
          cell_d[i] = cell_q[(i == 0) ? 0 : i - 1];
        end
      end else if (cmd_i.remove && (i < Depth - 1)) begin
        cell_d[i] = cell_q[(i < Depth - 1) ? i + 1 : i];
      end
    end

    always_ff @(posedge clk_i) begin
      cell_q[i] <= cell_d[i];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.remove) begin
      count_d = count_q - CntW'(1);
    end
  end

  assign occ_ext = {{OccW{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_q <= cmd_i.remove ? cell_q[0] : '0;
      occ_q <= occ_ext[OccW-1:0];
    end
  end

  assign res_rec_o   = res_q;
  assign occupancy_o = occ_q;

endmodule

>>> rtl/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded min priority queue of records, equal priorities leave in order.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per transfer: tuser selects insert (0) or
//   remove (1), tdata holds the record to insert (ignored on remove).
//   m_axis returns one result per request: tuser holds the status (ok, empty
//   on remove, full on insert), tdata the removed record (zero otherwise)
//   and the occupancy after the request.
//   Latency: the result is valid in the cycle after the request is taken.
//   Throughput: one request per cycle; the queue is a row of Depth cells
//   that all compare against the new priority in parallel and shift by one
//   place at once, and one result register holds the answer.
//   When the receiver stalls, the result register stays full and s_axis
//   tready drops; it rises again in the cycle the result is taken.
//   Reset empties the queue at once (count to zero) and clears the result
//   valid; record cells are not cleared, only held cells are ever read.
// ----------------------------------------------------------------------------
module stable_priority_queue import spq_pkg::*; #(
  parameter int unsigned Depth = DefaultDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // priority_req[7:0], age[15:8], name_part0[79:16], name_part1[143:80],
  // name_part2[175:144]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // action[0]
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // out_priority[7:0], out_age[15:8], out_name_part0[79:16],
  // out_name_part1[143:80], out_name_part2[175:144], occupancy[180:176], zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  // status[1:0]
  output logic [StatusW-1:0]  m_axis_tuser
);

  cmd_t            cmd;
  dp_stat_t        dp_stat;
  entry_t          in_rec;
  entry_t          res_rec;
  logic [OccW-1:0] occupancy;
  status_e         status;

  assign in_rec = entry_t'(s_axis_tdata[RecW-1:0]);

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .action_i    (action_e'(s_axis_tuser)),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .dp_stat_i   (dp_stat),
    .cmd_o       (cmd)
  );

  spq_dpath #(
    .Depth (Depth)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_rec_i    (in_rec),
    .dp_stat_o   (dp_stat),
    .res_rec_o   (res_rec),
    .occupancy_o (occupancy)
  );

  assign m_axis_tdata = {{(OutDataW - RecW - OccW){1'b0}}, occupancy, res_rec};
  assign m_axis_tuser = status;

endmodule

>>> rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port level checks of the stable priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_checker import spq_pkg::*; #(
  parameter int unsigned Depth = DefaultDepth
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [StatusW-1:0]  m_axis_tuser
);

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW+OccW-1:0] DepthExt = (CntW + OccW)'(Depth);

  logic [OccW-1:0] occ;
  logic            rec_zero;

  assign occ      = m_axis_tdata[RecW+OccW-1:RecW];
  assign rec_zero = (m_axis_tdata[RecW-1:0] == '0);

  // every taken request answers in the next cycle
  `SPQ_ASSERT_NEXT(a_one_cycle_result, s_axis_tvalid && s_axis_tready, m_axis_tvalid,
    "no result after accepted request")

  // a full reject reports a full queue and no record
  `SPQ_ASSERT_IMP(a_full_status, m_axis_tvalid && (m_axis_tuser == ST_FULL),
    (occ == DepthExt[OccW-1:0]) && rec_zero, "full status with wrong payload")

  // an empty remove reports zero occupancy and no record
  `SPQ_ASSERT_IMP(a_empty_status, m_axis_tvalid && (m_axis_tuser == ST_EMPTY),
    (occ == '0) && rec_zero, "empty status with wrong payload")

  // stalled result holds
  `SPQ_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
    "stalled result changed")

endmodule

bind stable_priority_queue spq_checker #(
  .Depth (Depth)
) u_spq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stable priority queue: requests are streamed
// in with random gaps, results are drained with random stalls, and every
// result is compared field by field against a sorted record list kept here.
// ----------------------------------------------------------------------------
module tb;
  import spq_pkg::*;

  localparam int unsigned QDepth     = DefaultDepth;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldOff    = 80;

  typedef struct {
    status_e           status;
    entry_t            rec;
    logic [OccW-1:0]   occ;
  } reply_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [StatusW-1:0]  m_axis_tuser;

  entry_t      ranked_records[$];  // records held, most urgent first
  reply_t      reply_q[$];         // results still owed by the block
  int          mismatches  = 0;
  int unsigned cycle_count = 0;
  int          hold_off_req = 0;
  int          rx_stall_left = 0;
  bit          src_gaps_on  = 1'b0;
  bit          rx_stalls_on = 1'b0;

  stable_priority_queue #(
    .Depth(QDepth)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // insert keeps equal priorities in arrival order, remove takes the head
  function automatic reply_t serve_request(action_e act, entry_t rec);
    reply_t r;
    int     pos;
    r.status = ST_OK;
    r.rec    = '0;
    if (act == ACT_INSERT) begin
      if (ranked_records.size() >= QDepth) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < ranked_records.size() && ranked_records[pos].pri <= rec.pri) pos++;
        ranked_records.insert(pos, rec);
      end
    end else if (ranked_records.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.rec = ranked_records.pop_front();
    end
    r.occ = OccW'(ranked_records.size());
    return r;
  endfunction

  function automatic entry_t random_record(int pri_lo, int pri_hi);
    entry_t rec;
    rec.pri    = PriW'($urandom_range(pri_hi, pri_lo));
    rec.age    = AgeW'($urandom);
    rec.name_a = {$urandom, $urandom};
    rec.name_b = {$urandom, $urandom};
    rec.name_c = $urandom;
    return rec;
  endfunction

  function automatic entry_t make_record(logic [PriW-1:0] pri, logic [7:0] tag);
    entry_t rec;
    rec        = random_record(0, 0);
    rec.pri    = pri;
    rec.age    = tag;
    return rec;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(action_e act, entry_t rec);
    if (src_gaps_on && $urandom_range(3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'(rec);
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    reply_q.push_back(serve_request(act, rec));
    @(negedge clk_i);
  endtask

  // receiver: random stall bursts plus one long requested hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_off_req != 0) begin
        rx_stall_left = hold_off_req;
        hold_off_req  = 0;
      end
      if (rx_stall_left > 0) begin
        rx_stall_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_stalls_on && $urandom_range(4) == 0) begin
        rx_stall_left = $urandom_range(14, 1) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h, got %0h", what, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : check_replies
    reply_t want;
    entry_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (reply_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %0h", m_axis_tdata);
      end else begin
        want = reply_q.pop_front();
        got  = m_axis_tdata[RecW-1:0];
        check_field("status", want.status, m_axis_tuser);
        check_field("priority", want.rec.pri, got.pri);
        check_field("age", want.rec.age, got.age);
        check_field("name_part0", want.rec.name_a, got.name_a);
        check_field("name_part1", want.rec.name_b, got.name_b);
        check_field("name_part2", want.rec.name_c, got.name_c);
        check_field("occupancy", want.occ, m_axis_tdata[RecW+OccW-1:RecW]);
      end
    end
  end

  task automatic test_remove_empty();
    send_request(ACT_REMOVE, random_record(0, 255));
  endtask

  task automatic test_field_extremes();
    entry_t lo_rec;
    entry_t hi_rec;
    lo_rec = '0;
    lo_rec.pri = '1;
    hi_rec = '1;
    hi_rec.pri = '0;
    send_request(ACT_INSERT, lo_rec);
    send_request(ACT_INSERT, hi_rec);
    send_request(ACT_REMOVE, '0);
    send_request(ACT_REMOVE, '1);
  endtask

  // equal priorities must come out in arrival order
  task automatic test_equal_priority_order();
    send_request(ACT_INSERT, make_record(8'd9, 8'd1));
    send_request(ACT_INSERT, make_record(8'd4, 8'd2));
    send_request(ACT_INSERT, make_record(8'd9, 8'd3));
    send_request(ACT_INSERT, make_record(8'd9, 8'd4));
    send_request(ACT_REMOVE, random_record(0, 255));
    send_request(ACT_REMOVE, random_record(0, 255));
  endtask

  task automatic test_fill_and_overflow();
    while (ranked_records.size() < QDepth) send_request(ACT_INSERT, random_record(0, 15));
    send_request(ACT_INSERT, random_record(0, 255));
  endtask

  // receiver holds off while the sender keeps offering, so s_axis stalls
  task automatic test_backpressure();
    src_gaps_on  = 1'b0;
    rx_stalls_on = 1'b0;
    // last request is already taken, do not offer it again
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    hold_off_req = HoldOff;
    @(negedge clk_i);
    for (int i = 0; i < 24; i++)
      send_request(i % 3 == 0 ? ACT_INSERT : ACT_REMOVE, random_record(0, 7));
  endtask

  task automatic run_segment(int count, int ins_pct, int pri_lo, int pri_hi);
    action_e act;
    for (int i = 0; i < count; i++) begin
      act = ($urandom_range(99) < ins_pct) ? ACT_INSERT : ACT_REMOVE;
      send_request(act, random_record(pri_lo, pri_hi));
    end
  endtask

  // segments swing between filling and draining, with narrow priority
  // ranges now and then so that ties are common
  task automatic test_random_mix(int total, bit idle_allowed);
    int sent;
    int n;
    int ins_pct;
    int pri_lo;
    int pri_hi;
    sent = 0;
    while (sent < total) begin
      n = $urandom_range(50, 20);
      case ($urandom_range(2))
        0: ins_pct = 80;
        1: ins_pct = 20;
        default: ins_pct = 50;
      endcase
      case ($urandom_range(3))
        0: begin pri_lo = 0; pri_hi = 3; end
        1: begin pri_lo = 252; pri_hi = 255; end
        default: begin pri_lo = 0; pri_hi = 255; end
      endcase
      src_gaps_on  = idle_allowed && ($urandom_range(3) != 0);
      rx_stalls_on = idle_allowed && ($urandom_range(3) != 0);
      run_segment(n, ins_pct, pri_lo, pri_hi);
      sent += n;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_INSERT;
    m_axis_tready = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_remove_empty();
    test_field_extremes();
    test_equal_priority_order();
    test_fill_and_overflow();
    test_random_mix(280, 1'b1);
    test_backpressure();
    test_random_mix(260, 1'b1);
    test_random_mix(60, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
